// ===== design/shb_pkg.sv =====
package shb_pkg;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_ABSORB        = 2'd0,
		OP_ABSORB_FINISH = 2'd1,
		OP_FINISH        = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL,
		ST_PAD,
		ST_OUT
	} state_t;

	// one decoded item as it travels from front to back
	typedef struct packed {
		logic       has_byte;
		logic       finish;
		logic [7:0] data;
	} cmd_t;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

// ===== design/sha256_byte_hasher_core.sv =====
// SHA-256 over a byte stream. Items enter a small command queue (QUEUE_DEPTH deep) and
// the hash engine drains it, taking message bytes back to back; each time 64 bytes
// have gathered the engine runs 64 rounds in the single round unit and then folds the
// result into the hash, during which full rises once the queue is taken up. A finish
// pads one byte per cycle up to the end of the block and runs one or two more
// compressions before the digest shows up as eight 32-bit words, word 0 first, one per
// pop. After the eighth word the engine starts over with a fresh message; items keep
// queueing while words wait.
module sha256_byte_hasher_core #(
	parameter int QUEUE_DEPTH = shb_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	logic          cmd_valid;
	logic          cmd_ready;
	shb_pkg::cmd_t cmd;

	shb_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.opcode(opcode),
		.data_byte(data_byte),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_ready(cmd_ready)
	);

	shb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_ready(cmd_ready),
		.empty(empty),
		.pop(pop),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word)
	);

endmodule

// ===== design/shb_front.sv =====
module shb_front #(
	parameter int QUEUE_DEPTH = shb_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [1:0]       opcode,
	input  logic [7:0]       data_byte,
	output logic             cmd_valid,
	output shb_pkg::cmd_t    cmd,
	input  logic             cmd_ready
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	shb_pkg::cmd_t     queue_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	shb_pkg::cmd_t     dec;
	logic              keep;
	logic              wr;
	logic              rd;

	// unused opcode is taken and dropped here
	always_comb begin
		dec.data = data_byte;
		dec.has_byte = 1'b0;
		dec.finish = 1'b0;
		keep = 1'b1;
		unique case (shb_pkg::opcode_t'(opcode))
			shb_pkg::OP_ABSORB: begin
				dec.has_byte = 1'b1;
			end
			shb_pkg::OP_ABSORB_FINISH: begin
				dec.has_byte = 1'b1;
				dec.finish = 1'b1;
			end
			shb_pkg::OP_FINISH: begin
				dec.finish = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign wr = push && !full && keep;
	assign cmd_valid = (count_q != '0);
	assign cmd = queue_q[rd_ptr_q];
	assign rd = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/shb_back.sv =====
module shb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  shb_pkg::cmd_t    cmd,
	output logic             cmd_ready,
	output logic             empty,
	input  logic             pop,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	shb_pkg::state_t state_q;
	shb_pkg::state_t state_d;

	logic [5:0]  fill_q;
	logic [23:0] acc_q;
	logic [31:0] win_q [16];
	logic [31:0] wk_q [8];
	logic [31:0] h_q [8];
	logic [60:0] len_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        fin_q;
	logic        first_q;
	logic        len_ok_q;
	logic        done_q;

	logic        take;
	logic        wr_en;
	logic [7:0]  wr_byte;
	logic [7:0]  pad_byte;
	logic [63:0] bits_sh;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_new;
	logic        last_pop;

	// length bytes go out most significant first at positions 56..63
	assign bits_sh = {len_q, 3'b000} << {fill_q[2:0], 3'b000};

	always_comb begin
		if (first_q) begin
			pad_byte = 8'h80;
		end else if (len_ok_q && fill_q[5:3] == 3'b111) begin
			pad_byte = bits_sh[63:56];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign last_pop = pop && (idx_q == 3'd7);

	always_comb begin
		state_d = state_q;
		cmd_ready = 1'b0;
		take = 1'b0;
		wr_en = 1'b0;
		wr_byte = cmd.data;
		unique case (state_q)
			shb_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					take = 1'b1;
					wr_en = cmd.has_byte;
					if (cmd.has_byte && fill_q == 6'd63) begin
						state_d = shb_pkg::ST_ROUND;
					end else if (cmd.finish) begin
						state_d = shb_pkg::ST_PAD;
					end
				end
			end
			shb_pkg::ST_ROUND: begin
				if (rnd_q == 6'd63) begin
					state_d = shb_pkg::ST_FINAL;
				end
			end
			shb_pkg::ST_FINAL: begin
				if (!fin_q) begin
					state_d = shb_pkg::ST_IDLE;
				end else if (done_q) begin
					state_d = shb_pkg::ST_OUT;
				end else begin
					state_d = shb_pkg::ST_PAD;
				end
			end
			shb_pkg::ST_PAD: begin
				wr_en = 1'b1;
				wr_byte = pad_byte;
				if (fill_q == 6'd63) begin
					state_d = shb_pkg::ST_ROUND;
				end
			end
			shb_pkg::ST_OUT: begin
				if (last_pop) begin
					state_d = shb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = shb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q <= '0;
			rnd_q <= '0;
			idx_q <= '0;
			fin_q <= 1'b0;
			first_q <= 1'b0;
			len_ok_q <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= shb_pkg::INIT_H[i];
			end
		end else begin
			if (take && cmd.finish) begin
				fin_q <= 1'b1;
				first_q <= 1'b1;
			end
			if (take && cmd.has_byte) begin
				len_q <= len_q + 1'b1;
			end
			if (wr_en) begin
				fill_q <= fill_q + 1'b1;
			end
			if (state_q == shb_pkg::ST_PAD) begin
				first_q <= 1'b0;
				if (first_q) begin
					len_ok_q <= (fill_q < 6'd56);
				end else if (len_ok_q && fill_q == 6'd63) begin
					done_q <= 1'b1;
				end
			end
			if (state_q == shb_pkg::ST_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (state_q == shb_pkg::ST_FINAL) begin
				// second padding block always carries the length
				if (fin_q) begin
					len_ok_q <= 1'b1;
				end
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + wk_q[i];
				end
			end
			if (state_q == shb_pkg::ST_OUT && pop) begin
				idx_q <= idx_q + 1'b1;
				if (last_pop) begin
					len_q <= '0;
					fin_q <= 1'b0;
					len_ok_q <= 1'b0;
					done_q <= 1'b0;
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= shb_pkg::INIT_H[i];
					end
				end
			end
		end
	end

	// round logic
	always_comb begin
		t1 = wk_q[7]
			+ (rotr(wk_q[4], 6) ^ rotr(wk_q[4], 11) ^ rotr(wk_q[4], 25))
			+ ((wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]))
			+ shb_pkg::ROUND_K[rnd_q]
			+ win_q[0];
		t2 = (rotr(wk_q[0], 2) ^ rotr(wk_q[0], 13) ^ rotr(wk_q[0], 22))
			+ ((wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]));
		w_new = win_q[0]
			+ (rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3))
			+ win_q[9]
			+ (rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10));
	end

	// the 16-word window is the block buffer while filling and the schedule while rounding
	always_ff @(posedge clk) begin
		if (wr_en) begin
			acc_q <= {acc_q[15:0], wr_byte};
			if (fill_q[1:0] == 2'b11) begin
				for (int i = 0; i < 15; i++) begin
					win_q[i] <= win_q[i + 1];
				end
				win_q[15] <= {acc_q, wr_byte};
			end
			if (fill_q == 6'd63) begin
				for (int i = 0; i < 8; i++) begin
					wk_q[i] <= h_q[i];
				end
			end
		end
		if (state_q == shb_pkg::ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w_new;
			wk_q[0] <= t1 + t2;
			wk_q[1] <= wk_q[0];
			wk_q[2] <= wk_q[1];
			wk_q[3] <= wk_q[2];
			wk_q[4] <= wk_q[3] + t1;
			wk_q[5] <= wk_q[4];
			wk_q[6] <= wk_q[5];
			wk_q[7] <= wk_q[6];
		end
	end

	assign empty = (state_q != shb_pkg::ST_OUT);
	assign digest_word = h_q[idx_q];
	assign word_index = idx_q;
	assign last_word = (idx_q == 3'd7);

endmodule

// ===== design/shb_checker.sv =====
module shb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// a waiting word holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(digest_word) && $stable(word_index))
		else $error("result beat changed while waiting");

	// words of a digest come in order with no gap
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last_word |=>
			!empty && word_index == 3'($past(word_index) + 3'd1))
		else $error("digest word out of order");

	// nothing follows the last word until a new message is hashed
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && last_word |=> empty)
		else $error("result beat after last word");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> last_word == (word_index == 3'd7))
		else $error("last word flag mismatch");

endmodule

bind sha256_byte_hasher_core shb_checker u_shb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.empty(empty),
	.pop(pop),
	.digest_word(digest_word),
	.word_index(word_index),
	.last_word(last_word)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 500;
	localparam int RANDOM_ITEMS = 300;
	localparam int MIN_MESSAGES = 12;

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [255:0] DIGEST_EMPTY =
		256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
	localparam logic [255:0] DIGEST_ABC =
		256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

	typedef struct packed {
		logic [1:0]   op;
		logic [7:0]   data;
		logic         typed;
		logic [255:0] digest;
	} stim_row_t;

	localparam int DIR_ROWS = 15;
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		'{shb_pkg::OP_FINISH,        8'h00, 1'b1, DIGEST_EMPTY},
		'{shb_pkg::OP_ABSORB,        8'h61, 1'b0, 256'h0},
		'{shb_pkg::OP_ABSORB,        8'h62, 1'b0, 256'h0},
		'{shb_pkg::OP_ABSORB_FINISH, 8'h63, 1'b1, DIGEST_ABC},
		'{OP_UNUSED,                 8'hff, 1'b0, 256'h0},
		'{shb_pkg::OP_ABSORB_FINISH, 8'h00, 1'b0, 256'h0},
		'{shb_pkg::OP_ABSORB,        8'hff, 1'b0, 256'h0},
		'{OP_UNUSED,                 8'h00, 1'b0, 256'h0},
		'{shb_pkg::OP_FINISH,        8'hff, 1'b0, 256'h0},
		'{shb_pkg::OP_ABSORB_FINISH, 8'hff, 1'b0, 256'h0},
		'{shb_pkg::OP_FINISH,        8'h5a, 1'b1, DIGEST_EMPTY},
		'{shb_pkg::OP_ABSORB,        8'h61, 1'b0, 256'h0},
		'{OP_UNUSED,                 8'h78, 1'b0, 256'h0},
		'{shb_pkg::OP_ABSORB,        8'h62, 1'b0, 256'h0},
		'{shb_pkg::OP_ABSORB_FINISH, 8'h63, 1'b1, DIGEST_ABC}
	};

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [1:0]  opcode = 2'd0;
	logic [7:0]  data_byte = 8'h00;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	// model of the hash engine
	logic [31:0] chain_h [8];
	logic [7:0]  msg_block [64];
	int          block_fill;
	logic [63:0] msg_bit_count;
	logic [31:0] digest_out [8];

	digest_beat_t digest_fifo [$];
	int err_count = 0;
	int cycle_count = 0;
	int item_count = 0;
	int snd_burst = 0;

	sha256_byte_hasher_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.data_byte   (data_byte),
		.empty       (empty),
		.pop         (pop),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void hash_init();
		for (int i = 0; i < 8; i++) chain_h[i] = SHA_IV[i];
		for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
		block_fill = 0;
		msg_bit_count = 64'd0;
	endfunction

	function automatic void hash_compress();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h;
		logic [31:0] s0, s1, ch, mj, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
		e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
		for (int i = 0; i < 64; i++) begin
			s1 = rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25);
			ch = (e & f) ^ (~e & g);
			t1 = h + s1 + ch + SHA_K[i] + w[i];
			s0 = rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22);
			mj = (a & b) ^ (a & c) ^ (b & c);
			t2 = s0 + mj;
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
		chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
	endfunction

	// returns 1 when the item finishes a message; digest lands in digest_out
	function automatic bit hash_step(input logic [1:0] op, input logic [7:0] b);
		int n;
		if (op == OP_UNUSED)
			return 1'b0;
		if (op != shb_pkg::OP_FINISH) begin
			msg_block[block_fill] = b;
			block_fill++;
			msg_bit_count += 64'd8;
			if (block_fill == 64) begin
				hash_compress();
				block_fill = 0;
			end
		end
		if (op == shb_pkg::OP_ABSORB)
			return 1'b0;
		n = block_fill;
		msg_block[n] = 8'h80;
		n++;
		// no room for the length: pad out and run an extra block
		if (n > 56) begin
			while (n < 64) begin
				msg_block[n] = 8'h00;
				n++;
			end
			hash_compress();
			n = 0;
		end
		while (n < 56) begin
			msg_block[n] = 8'h00;
			n++;
		end
		for (int i = 0; i < 8; i++)
			msg_block[56+i] = msg_bit_count[63-8*i -: 8];
		hash_compress();
		for (int i = 0; i < 8; i++) digest_out[i] = chain_h[i];
		hash_init();
		return 1'b1;
	endfunction

	// idle cycles before the next beat, with occasional stretches of none
	function automatic int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			burst = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [7:0] b,
		input logic typed, input logic [255:0] dg);
		int gap;
		digest_beat_t beat;
		gap = draw_wait(snd_burst);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		data_byte <= b;
		do @(posedge clk); while (full);
		if (op != OP_UNUSED)
			item_count++;
		if (hash_step(op, b)) begin
			for (int i = 0; i < 8; i++) begin
				beat.word = typed ? dg[255-32*i -: 32] : digest_out[i];
				beat.index = i[2:0];
				beat.last = (i == 7);
				digest_fifo.push_back(beat);
			end
		end
	endtask

	function automatic logic [7:0] draw_byte();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 8'hff : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		int msg_count;
		int msg_len;
		int pick;
		bit end_with_byte;
		hash_init();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++)
			send_item(DIR_TABLE[r].op, DIR_TABLE[r].data, DIR_TABLE[r].typed,
				DIR_TABLE[r].digest);

		msg_count = 0;
		item_count = 0;
		while (item_count < RANDOM_ITEMS || msg_count < MIN_MESSAGES) begin
			// lengths cluster around the block and padding boundaries
			pick = $urandom_range(0, 99);
			if (pick < 45)
				msg_len = $urandom_range(0, 6);
			else if (pick < 85)
				msg_len = $urandom_range(52, 72);
			else
				msg_len = $urandom_range(118, 130);
			end_with_byte = (msg_len > 0) && $urandom_range(0, 1);
			for (int i = 0; i < msg_len; i++) begin
				if ($urandom_range(0, 24) == 0)
					send_item(OP_UNUSED, draw_byte(), 1'b0, 256'h0);
				if (end_with_byte && i == msg_len - 1)
					send_item(shb_pkg::OP_ABSORB_FINISH, draw_byte(), 1'b0, 256'h0);
				else
					send_item(shb_pkg::OP_ABSORB, draw_byte(), 1'b0, 256'h0);
			end
			if (!end_with_byte)
				send_item(shb_pkg::OP_FINISH, draw_byte(), 1'b0, 256'h0);
			msg_count++;
		end
		push <= 1'b0;

		while (digest_fifo.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// digest beat sink
	initial begin
		int stall;
		int rcv_burst;
		digest_beat_t exp_beat;
		rcv_burst = 0;
		wait (arst_n);
		forever begin
			stall = draw_wait(rcv_burst);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (digest_fifo.size() == 0) begin
				err_count++;
				$display("%0t: unexpected digest beat word %h index %0d last %b",
					$time, digest_word, word_index, last_word);
			end else begin
				exp_beat = digest_fifo.pop_front();
				if (digest_word !== exp_beat.word) begin
					err_count++;
					$display("%0t: digest_word expected %h actual %h",
						$time, exp_beat.word, digest_word);
				end
				if (word_index !== exp_beat.index) begin
					err_count++;
					$display("%0t: word_index expected %0d actual %0d",
						$time, exp_beat.index, word_index);
				end
				if (last_word !== exp_beat.last) begin
					err_count++;
					$display("%0t: last_word expected %b actual %b",
						$time, exp_beat.last, last_word);
				end
			end
		end
	end

endmodule
